>>> rtl/core/scd_pkg.sv
package scd_pkg;

  // Depth of each delay ring and entries in one full sine period.
  localparam int DELAY_DEPTH     = 1024;
  localparam int SINE_TABLE_SIZE = 1024;

  localparam int RING_AW    = $clog2(DELAY_DEPTH);
  localparam int SINE_AW    = $clog2(SINE_TABLE_SIZE);
  localparam int SINE_QAW   = SINE_AW - 2;
  localparam int SINE_QTR   = SINE_TABLE_SIZE / 4;
  localparam int PHASE_W    = 32;
  localparam int LFO_FRAC_W = PHASE_W - SINE_AW;

  localparam int SAMPLE_W  = 24;
  localparam int MIX_W     = 16;
  localparam int DELAY_W   = 18;
  localparam int POS_FRAC_W = 8;
  localparam int DLY_W     = RING_AW + POS_FRAC_W;
  localparam int SWING_W   = 20;
  localparam int SDLY_W    = (DLY_W + 1 > 21) ? DLY_W + 1 : 21;
  localparam int DLY_MIN   = 1 << POS_FRAC_W;
  localparam int DLY_MAX   = (DELAY_DEPTH - 2) << POS_FRAC_W;

  localparam logic [MIX_W-1:0] MIX_BYPASS_LIMIT = 16'd66;

  // Configuration register map.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_AMOUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_ENABLE = 3'd4;

  localparam logic [MIX_W-1:0]   RST_MIX_AMOUNT = 16'd0;
  localparam logic [PHASE_W-1:0] RST_LFO_STEP   = 32'd44739;
  localparam logic [DELAY_W-1:0] RST_BASE_DELAY = 18'd36864;
  localparam logic [DELAY_W-1:0] RST_MOD_DEPTH  = 18'd12288;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SINE,
    ST_INTERP,
    ST_SWING,
    ST_DELAY,
    ST_RDA,
    ST_RDB,
    ST_WET,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic step;
    logic ld_sine;
    logic ld_interp;
    logic ld_swing;
  } lfo_ctl_t;

  typedef struct packed {
    logic we;
    logic wzero;
    logic ld_pos;
    logic rd_next;
    logic ld_a;
    logic ld_wet;
  } lane_ctl_t;

  // Quarter-wave sine table, entries 0 to SINE_QTR inclusive, built at elaboration.
  typedef logic [SAMPLE_W-1:0] sine_qtr_t [SINE_QTR+1];

  function automatic sine_qtr_t build_sine_qtr();
    sine_qtr_t   tab;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    for (int j = 0; j <= SINE_QTR; j++) begin
      r  = 64'(j) << (30 - SINE_QAW);
      x  = (r * 64'd6746518852) >> 32;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd156;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd110;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd72;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
      t  = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      s  = (s + 64'd64) >> 7;
      if (s > 64'd8388607) begin
        s = 64'd8388607;
      end
      tab[j] = s[SAMPLE_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_qtr_t SINE_TAB = build_sine_qtr();

  // Full-period sine entry by folding the quarter table.
  function automatic logic signed [SAMPLE_W-1:0] sine_at(input logic [SINE_AW-1:0] idx);
    logic [1:0]          quad;
    logic [SINE_QAW-1:0] j;
    logic [SINE_QAW:0]   f;
    logic [SAMPLE_W-1:0] m;
    quad = idx[SINE_AW-1 -: 2];
    j    = idx[SINE_QAW-1:0];
    f    = quad[0] ? (SINE_QAW+1)'(SINE_QTR) - {1'b0, j} : {1'b0, j};
    m    = SINE_TAB[f];
    return quad[1] ? -$signed(m) : $signed(m);
  endfunction

endpackage

>>> rtl/core/stereo_chorus_delay.sv
// Stereo chorus: each transfer on the input channel carries one left/right sample
// pair and yields exactly one pair on the output channel, chorused unless bypassed.
// After reset the block sweeps both 1024-entry delay rings to zero, one entry per
// cycle, and in_ready stays low until the sweep ends; configuration writes are
// taken at any time (cfg_ready is tied high) but should only be issued while no
// sample is in flight. Items are processed one at a time. A processed item steps
// through the states SINE, INTERP, SWING, DELAY, RDA, RDB, WET and MIX from its
// input transfer until its result sits in the output register, and MIX waits for
// a free output register; the next input is accepted only back in IDLE. The states
// carry out, in order, sine lookup, LFO interpolation multiply, depth multiply,
// delay computation, two reads through the single read port of each ring, wet
// interpolation multiply and mix multiply. When mix_amount is below 66 the pair
// goes from IDLE straight to MIX and reaches the output register unchanged, and
// no state moves. The output register holds a finished result while the consumer
// stalls, and the block already accepts the next input meanwhile.
module stereo_chorus_delay (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  scd_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output scd_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [scd_pkg::MIX_W-1:0]   mix_amount_r;
  logic [scd_pkg::PHASE_W-1:0] lfo_step_r;
  logic [scd_pkg::DELAY_W-1:0] base_delay_r;
  logic [scd_pkg::DELAY_W-1:0] mod_depth_r;
  logic                        stereo_en_r;

  // Sequencer and item state.
  scd_pkg::state_t             state_r;
  scd_pkg::state_t             state_nxt;
  logic [scd_pkg::RING_AW-1:0] wi_r;
  logic                        bypass_r;
  scd_pkg::in_t                dry_r;
  scd_pkg::out_t               out_data_r;
  logic                        out_valid_r;

  logic                        in_xfer;
  logic                        bypass_now;
  logic                        slot_free;
  logic                        out_load;
  logic                        wi_step;
  scd_pkg::lfo_ctl_t           lfo_ctl;
  scd_pkg::lane_ctl_t          lane_ctl;
  scd_pkg::lane_ctl_t          lane_ctl_right;
  logic signed [scd_pkg::SWING_W-1:0]  swing;
  logic signed [scd_pkg::SAMPLE_W-1:0] left_wet;
  logic signed [scd_pkg::SAMPLE_W-1:0] right_wet;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_amount_r <= scd_pkg::RST_MIX_AMOUNT;
      lfo_step_r   <= scd_pkg::RST_LFO_STEP;
      base_delay_r <= scd_pkg::RST_BASE_DELAY;
      mod_depth_r  <= scd_pkg::RST_MOD_DEPTH;
      stereo_en_r  <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        scd_pkg::CFG_MIX_AMOUNT:    mix_amount_r <= cfg_data[scd_pkg::MIX_W-1:0];
        scd_pkg::CFG_LFO_STEP:      lfo_step_r   <= cfg_data[scd_pkg::PHASE_W-1:0];
        scd_pkg::CFG_BASE_DELAY:    base_delay_r <= cfg_data[scd_pkg::DELAY_W-1:0];
        scd_pkg::CFG_MOD_DEPTH:     mod_depth_r  <= cfg_data[scd_pkg::DELAY_W-1:0];
        scd_pkg::CFG_STEREO_ENABLE: stereo_en_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign in_xfer    = in_valid && in_ready;
  assign bypass_now = mix_amount_r < scd_pkg::MIX_BYPASS_LIMIT;
  // The output register can take a new result when it is empty or being drained.
  assign slot_free  = !out_valid_r || out_ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scd_pkg::ST_CLEAR: begin
        if (wi_r == scd_pkg::RING_AW'(scd_pkg::DELAY_DEPTH - 1)) begin
          state_nxt = scd_pkg::ST_IDLE;
        end
      end
      scd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bypass_now ? scd_pkg::ST_MIX : scd_pkg::ST_SINE;
        end
      end
      scd_pkg::ST_SINE:   state_nxt = scd_pkg::ST_INTERP;
      scd_pkg::ST_INTERP: state_nxt = scd_pkg::ST_SWING;
      scd_pkg::ST_SWING:  state_nxt = scd_pkg::ST_DELAY;
      scd_pkg::ST_DELAY:  state_nxt = scd_pkg::ST_RDA;
      scd_pkg::ST_RDA:    state_nxt = scd_pkg::ST_RDB;
      scd_pkg::ST_RDB:    state_nxt = scd_pkg::ST_WET;
      scd_pkg::ST_WET:    state_nxt = scd_pkg::ST_MIX;
      scd_pkg::ST_MIX: begin
        if (slot_free) begin
          state_nxt = scd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scd_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    wi_step  = 1'b0;
    lfo_ctl  = '0;
    lane_ctl = '0;
    case (state_r)
      scd_pkg::ST_CLEAR: begin
        lane_ctl.we    = 1'b1;
        lane_ctl.wzero = 1'b1;
        wi_step        = 1'b1;
      end
      scd_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        lfo_ctl.step = in_valid && !bypass_now;
      end
      scd_pkg::ST_SINE:   lfo_ctl.ld_sine   = 1'b1;
      scd_pkg::ST_INTERP: lfo_ctl.ld_interp = 1'b1;
      scd_pkg::ST_SWING:  lfo_ctl.ld_swing  = 1'b1;
      scd_pkg::ST_DELAY: begin
        // The dry sample goes into the ring before the taps are read, so a tap
        // that lands on the current write slot sees it.
        lane_ctl.we     = 1'b1;
        lane_ctl.ld_pos = 1'b1;
      end
      scd_pkg::ST_RDA: begin
      end
      scd_pkg::ST_RDB: begin
        lane_ctl.rd_next = 1'b1;
        lane_ctl.ld_a    = 1'b1;
      end
      scd_pkg::ST_WET:    lane_ctl.ld_wet = 1'b1;
      scd_pkg::ST_MIX: begin
        out_load = slot_free;
        wi_step  = slot_free && !bypass_r;
      end
      default: begin
      end
    endcase
  end

  // The right ring is cleared after reset but skipped on items while the right
  // channel is disabled.
  always_comb begin
    lane_ctl_right    = lane_ctl;
    lane_ctl_right.we = lane_ctl.we && (lane_ctl.wzero || stereo_en_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scd_pkg::ST_CLEAR;
      wi_r        <= '0;
      out_valid_r <= 1'b0;
      bypass_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wi_step) begin
        wi_r <= wi_r + scd_pkg::RING_AW'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        bypass_r <= bypass_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dry_r <= in_data;
    end
  end

  scd_lfo u_lfo (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lfo_ctl),
    .lfo_step (lfo_step_r),
    .mod_depth(mod_depth_r),
    .swing    (swing)
  );

  // Left lane reads behind the write slot by base plus swing.
  scd_lane u_lane_left (
    .clk       (clk),
    .ctl       (lane_ctl),
    .wr_idx    (wi_r),
    .dry       (dry_r.left_in),
    .swing     (swing),
    .base_delay(base_delay_r),
    .mix_amount(mix_amount_r),
    .neg_swing (1'b0),
    .result    (left_wet)
  );

  // Right lane reads behind the write slot by base minus swing.
  scd_lane u_lane_right (
    .clk       (clk),
    .ctl       (lane_ctl_right),
    .wr_idx    (wi_r),
    .dry       (dry_r.right_in),
    .swing     (swing),
    .base_delay(base_delay_r),
    .mix_amount(mix_amount_r),
    .neg_swing (1'b1),
    .result    (right_wet)
  );

  // Merge stage: choose lane results or the dry samples for the output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.left_out  <= bypass_r ? dry_r.left_in : left_wet;
      out_data_r.right_out <= (bypass_r || !stereo_en_r) ? dry_r.right_in : right_wet;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/scd_ram.sv
module scd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/scd_lfo.sv
module scd_lfo (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  scd_pkg::lfo_ctl_t                      ctl,
  input  logic [scd_pkg::PHASE_W-1:0]            lfo_step,
  input  logic [scd_pkg::DELAY_W-1:0]            mod_depth,
  output logic signed [scd_pkg::SWING_W-1:0]     swing
);

  localparam int DIFF_W = scd_pkg::SAMPLE_W + 1;
  localparam int ILP_W  = DIFF_W + scd_pkg::LFO_FRAC_W + 1;
  localparam int SWP_W  = scd_pkg::SAMPLE_W + scd_pkg::DELAY_W + 1;

  logic [scd_pkg::PHASE_W-1:0]         phase_r;
  logic [scd_pkg::SINE_AW-1:0]         idx0;
  logic [scd_pkg::SINE_AW-1:0]         idx1;
  logic [scd_pkg::LFO_FRAC_W-1:0]      frac;
  logic signed [scd_pkg::SAMPLE_W-1:0] s0_r;
  logic signed [DIFF_W-1:0]            diff_r;
  logic signed [scd_pkg::SAMPLE_W-1:0] lfo_r;
  logic signed [scd_pkg::SWING_W-1:0]  swing_r;
  logic signed [ILP_W-1:0]             ilp_prod;
  logic signed [DIFF_W-1:0]            lfo_sum;
  logic signed [SWP_W-1:0]             swing_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (ctl.step) begin
      phase_r <= phase_r + lfo_step;
    end
  end

  assign idx0 = phase_r[scd_pkg::PHASE_W-1 -: scd_pkg::SINE_AW];
  assign idx1 = idx0 + scd_pkg::SINE_AW'(1);
  assign frac = phase_r[scd_pkg::LFO_FRAC_W-1:0];

  // The phase bits below the table index weight the step between neighbors.
  assign ilp_prod   = ILP_W'(diff_r) * ILP_W'($signed({1'b0, frac}));
  assign lfo_sum    = DIFF_W'(s0_r) + DIFF_W'(ilp_prod >>> scd_pkg::LFO_FRAC_W);
  assign swing_prod = SWP_W'(lfo_r) * SWP_W'($signed({1'b0, mod_depth}));

  always_ff @(posedge clk) begin
    if (ctl.ld_sine) begin
      s0_r   <= scd_pkg::sine_at(idx0);
      diff_r <= DIFF_W'(scd_pkg::sine_at(idx1)) - DIFF_W'(scd_pkg::sine_at(idx0));
    end
    if (ctl.ld_interp) begin
      lfo_r <= lfo_sum[scd_pkg::SAMPLE_W-1:0];
    end
    if (ctl.ld_swing) begin
      swing_r <= scd_pkg::SWING_W'(swing_prod >>> (scd_pkg::SAMPLE_W - 1));
    end
  end

  assign swing = swing_r;

endmodule

>>> rtl/core/scd_lane.sv
module scd_lane (
  input  logic                                clk,
  input  scd_pkg::lane_ctl_t                  ctl,
  input  logic [scd_pkg::RING_AW-1:0]         wr_idx,
  input  logic signed [scd_pkg::SAMPLE_W-1:0] dry,
  input  logic signed [scd_pkg::SWING_W-1:0]  swing,
  input  logic [scd_pkg::DELAY_W-1:0]         base_delay,
  input  logic [scd_pkg::MIX_W-1:0]           mix_amount,
  input  logic                                neg_swing,
  output logic signed [scd_pkg::SAMPLE_W-1:0] result
);

  localparam int SW    = scd_pkg::SAMPLE_W;
  localparam int DW    = SW + 1;
  localparam int WP_W  = DW + scd_pkg::POS_FRAC_W + 1;
  localparam int MP_W  = SW + 19;
  localparam int OUT_W = SW + 2;

  logic signed [scd_pkg::SDLY_W-1:0] base_s;
  logic signed [scd_pkg::SDLY_W-1:0] swing_s;
  logic signed [scd_pkg::SDLY_W-1:0] d_sum;
  logic [scd_pkg::DLY_W-1:0]         d_sat;
  logic [scd_pkg::DLY_W-1:0]         pos;
  logic [scd_pkg::RING_AW-1:0]       i0_r;
  logic [scd_pkg::POS_FRAC_W-1:0]    f_r;
  logic [scd_pkg::RING_AW-1:0]       raddr;
  logic [SW-1:0]                     rdata;
  logic signed [SW-1:0]              rd_s;
  logic signed [SW-1:0]              a_r;
  logic signed [SW-1:0]              wet_r;
  logic signed [DW-1:0]              diff_b;
  logic signed [WP_W-1:0]            wet_prod;
  logic signed [DW+1:0]              wet_w;
  logic signed [DW-1:0]              diff_m;
  logic signed [MP_W-1:0]            mix_prod;
  logic signed [MP_W-1:0]            acc;
  logic signed [OUT_W-1:0]           out_w;

  // Total delay in Q8 samples, held between one sample and depth minus two.
  assign base_s  = scd_pkg::SDLY_W'($signed({1'b0, base_delay}));
  assign swing_s = scd_pkg::SDLY_W'(swing);
  assign d_sum   = neg_swing ? base_s - swing_s : base_s + swing_s;

  always_comb begin
    if (d_sum < $signed(scd_pkg::SDLY_W'(scd_pkg::DLY_MIN))) begin
      d_sat = scd_pkg::DLY_W'(scd_pkg::DLY_MIN);
    end else if (d_sum > $signed(scd_pkg::SDLY_W'(scd_pkg::DLY_MAX))) begin
      d_sat = scd_pkg::DLY_W'(scd_pkg::DLY_MAX);
    end else begin
      d_sat = scd_pkg::DLY_W'(d_sum);
    end
  end

  // The ring wraps at a power of two, so the floored read position is a plain
  // modular subtraction.
  assign pos = {wr_idx, {scd_pkg::POS_FRAC_W{1'b0}}} - d_sat;

  assign raddr = ctl.rd_next ? i0_r + scd_pkg::RING_AW'(1) : i0_r;

  scd_ram #(
    .WIDTH(SW),
    .DEPTH(scd_pkg::DELAY_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ctl.we),
    .waddr(wr_idx),
    .wdata(ctl.wzero ? '0 : dry),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_s     = $signed(rdata);
  assign diff_b   = DW'(rd_s) - DW'(a_r);
  assign wet_prod = WP_W'(diff_b) * WP_W'($signed({1'b0, f_r}));
  assign wet_w    = (DW+2)'(a_r) + (DW+2)'(wet_prod >>> scd_pkg::POS_FRAC_W);

  always_ff @(posedge clk) begin
    if (ctl.ld_pos) begin
      i0_r <= pos[scd_pkg::DLY_W-1:scd_pkg::POS_FRAC_W];
      f_r  <= pos[scd_pkg::POS_FRAC_W-1:0];
    end
    if (ctl.ld_a) begin
      a_r <= rd_s;
    end
    if (ctl.ld_wet) begin
      wet_r <= wet_w[SW-1:0];
    end
  end

  // Dry and wet blend with round to nearest, then saturate to the sample range.
  assign diff_m   = DW'(wet_r) - DW'(dry);
  assign mix_prod = MP_W'(diff_m) * MP_W'($signed({1'b0, mix_amount}));
  assign acc      = (MP_W'(dry) <<< 17) + mix_prod + MP_W'(65536);
  assign out_w    = OUT_W'(acc >>> 17);

  always_comb begin
    if (out_w > $signed(OUT_W'(8388607))) begin
      result = 24'sh7FFFFF;
    end else if (out_w < -$signed(OUT_W'(8388608))) begin
      result = 24'sh800000;
    end else begin
      result = out_w[SW-1:0];
    end
  end

endmodule

>>> rtl/core/scd_checker.sv
module scd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input scd_pkg::out_t out_data
);

  // The ring clearing pass keeps the input closed right after reset.
  a_closed_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open right after reset");

  // Items are taken one at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer accepted while an item is in flight");

  // No result can appear in the cycle right after a transfer.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared without processing time");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output payload changed while stalled");

endmodule

bind stereo_chorus_delay scd_checker u_scd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
